@@ hw/rtl/footswitch_press_classifier_defines.svh @@
// Assertion macros for the footswitch press classifier.
// The enclosing scope must provide clk and rst_n.
`ifndef FOOTSWITCH_PRESS_CLASSIFIER_DEFINES_SVH
`define FOOTSWITCH_PRESS_CLASSIFIER_DEFINES_SVH

// Clocked property, disabled while in reset.
`define FPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define FPC_NEVER(label, expr, msg) \
    `FPC_ASSERT(label, !(expr), msg)

`endif

@@ hw/rtl/fpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_pkg
// Types and constants shared by the footswitch press classifier files.
// ----------------------------------------------------------------------------
package fpc_pkg;

    localparam int NUM_SWITCHES_DEF = 2;
    localparam int CFG_DATA_W       = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int TIME_W           = 32;
    localparam int TALLY_W          = 2;

    localparam logic [TALLY_W-1:0] TALLY_MAX = 2'd2;

    localparam logic       ENABLE_RST = 1'b0;
    localparam logic [2:0] MASK_RST   = 3'd7;
    localparam logic [15:0] HOLD_RST  = 16'd1000;
    localparam logic [15:0] WINDOW_RST = 16'd300;

    typedef enum logic [1:0] {
        KIND_NORMAL = 2'd0,
        KIND_DOUBLE = 2'd1,
        KIND_LONG   = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_MASK   = 2'd1,
        CFG_HOLD   = 2'd2,
        CFG_WINDOW = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic              switch_sel;
        logic              pressed;
        logic [TIME_W-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic       event_switch;
        logic [1:0] event_kind;
        logic       last_event;
    } event_t;

endpackage

@@ hw/rtl/fpc_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_in_if / fpc_ev_if
// Valid/ready channels for sample beats and event beats.
// ----------------------------------------------------------------------------
interface fpc_in_if
    import fpc_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fpc_ev_if
    import fpc_pkg::*;
();
    logic   valid;
    logic   ready;
    event_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/footswitch_press_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// footswitch_press_classifier
// Classifies footswitch presses into normal, double and long press events.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per debounced sample (switch_sel, pressed, now_ms).
//   out_ch : event beats (event_switch, event_kind, last_event); last_event
//            marks the final event caused by one sample.
//   cfg_*  : register writes, user-kept to no sample in flight; unenforced.
// A sample is registered on acceptance and classified in the next cycle;
// its events are then loaded into the event register when it frees. One
// sample per cycle is taken as long as each sample yields at most one
// event and the receiver keeps up. A sample that yields a normal plus a
// long press holds the event register for two beats. Samples that yield
// no event never wait for the event register.
// Reset clears all per-switch state and loads the register defaults
// (classification disabled). While the receiver stalls, the event beat is
// held, one more sample is parked in the input register, and in_ch.ready
// drops until the event register frees.
// ----------------------------------------------------------------------------
module footswitch_press_classifier
    import fpc_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    fpc_in_if.sink                in_ch,
    fpc_ev_if.source              out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

    // Configuration registers
    logic        enable_reg;
    logic [2:0]  mask_reg;
    logic [15:0] hold_reg;
    logic [15:0] window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= ENABLE_RST;
            mask_reg   <= MASK_RST;
            hold_reg   <= HOLD_RST;
            window_reg <= WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ENABLE: enable_reg <= cfg_data[0];
                CFG_MASK:   mask_reg   <= cfg_data[2:0];
                CFG_HOLD:   hold_reg   <= cfg_data;
                CFG_WINDOW: window_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Per-switch state
    logic               prev_level_reg      [NUM_SWITCHES];
    logic [TIME_W-1:0]  press_start_reg     [NUM_SWITCHES];
    logic [TIME_W-1:0]  prev_press_time_reg [NUM_SWITCHES];
    logic [TALLY_W-1:0] press_tally_reg     [NUM_SWITCHES];
    logic               single_pending_reg  [NUM_SWITCHES];
    logic [TIME_W-1:0]  pending_since_reg   [NUM_SWITCHES];
    logic               long_fired_reg      [NUM_SWITCHES];

    // Input register
    logic     s1_valid_reg;
    in_item_t s1_item_reg;

    // Event register: up to two queued events of one sample
    logic [1:0] ev_cnt_reg;
    logic       ev_sw_reg;
    kind_t      ev_k0_reg;
    kind_t      ev_k1_reg;

    logic out_pop;
    logic out_free;
    logic advance;
    logic commit;

    // Classification of the sample in the input register
    logic               in_range;
    logic               active;
    logic [IDX_W-1:0]   idx;
    logic [TIME_W-1:0]  now;
    logic [TIME_W-1:0]  hold32;
    logic [TIME_W-1:0]  window32;
    logic [TIME_W-1:0]  since_gap;
    logic [TIME_W-1:0]  press_gap;
    logic [TIME_W-1:0]  duration;
    logic               lvl;
    logic               pl;
    logic               expired;
    logic               rise;
    logic               fall;
    logic               fire_long;
    logic               fire_double;
    logic               long_after_rise;
    logic [TALLY_W-1:0] tally_a;
    logic [TALLY_W-1:0] tally_b;
    logic               pend_a;
    logic               hit_n;
    logic               hit_l;
    logic               hit_d;

    logic               lf_next;
    logic [TALLY_W-1:0] tally_next;
    logic               pend_next;
    logic [TIME_W-1:0]  since_next;
    logic [TIME_W-1:0]  start_next;
    logic [TIME_W-1:0]  ppt_next;
    logic [1:0]         new_cnt;
    kind_t              new_k0;
    kind_t              new_k1;

    assign in_range = (32'(s1_item_reg.switch_sel) < 32'(NUM_SWITCHES));
    assign active   = enable_reg && in_range;
    assign idx      = in_range ? IDX_W'(s1_item_reg.switch_sel) : '0;
    assign now      = s1_item_reg.now_ms;
    assign lvl      = s1_item_reg.pressed;
    assign hold32   = {16'b0, hold_reg};
    assign window32 = {16'b0, window_reg};

    always_comb
    begin
        pl        = prev_level_reg[idx];
        since_gap = now - pending_since_reg[idx];
        press_gap = now - prev_press_time_reg[idx];

        // Release a deferred single press whose window ran out
        expired = single_pending_reg[idx] && (since_gap >= window32);
        pend_a  = expired ? 1'b0 : single_pending_reg[idx];
        tally_a = expired ? '0 : press_tally_reg[idx];

        // New press
        rise       = lvl && !pl;
        start_next = rise ? now : press_start_reg[idx];
        ppt_next   = rise ? now : prev_press_time_reg[idx];
        if (!rise)
            tally_b = tally_a;
        else if (press_gap <= window32)
            tally_b = (tally_a < TALLY_MAX) ? tally_a + 1'b1 : tally_a;
        else
            tally_b = TALLY_W'(1);
        long_after_rise = rise ? 1'b0 : long_fired_reg[idx];

        // A press that starts here has zero duration
        duration  = rise ? '0 : (now - press_start_reg[idx]);
        fire_long = lvl && (duration >= hold32) && !long_after_rise;

        lf_next    = fire_long ? 1'b1 : long_after_rise;
        tally_next = fire_long ? '0 : tally_b;
        pend_next  = fire_long ? 1'b0 : pend_a;
        since_next = pending_since_reg[idx];

        // Release: double press or deferred single press
        fall        = !lvl && pl && !lf_next;
        fire_double = fall && (tally_next >= TALLY_MAX);
        if (fire_double)
        begin
            tally_next = '0;
            pend_next  = 1'b0;
        end
        else if (fall && (duration < hold32))
        begin
            pend_next  = 1'b1;
            since_next = now;
        end

        hit_n = active && expired && mask_reg[KIND_NORMAL];
        hit_l = active && fire_long && mask_reg[KIND_LONG];
        hit_d = active && fire_double && mask_reg[KIND_DOUBLE];

        new_cnt = {1'b0, hit_n} + {1'b0, hit_l || hit_d};
        new_k1  = hit_l ? KIND_LONG : KIND_DOUBLE;
        new_k0  = hit_n ? KIND_NORMAL : new_k1;
    end

    assign out_pop  = (ev_cnt_reg != 2'd0) && out_ch.ready;
    assign out_free = (ev_cnt_reg == 2'd0) || ((ev_cnt_reg == 2'd1) && out_ch.ready);
    assign advance  = s1_valid_reg && ((new_cnt == 2'd0) || out_free);
    assign commit   = advance && active;

    assign in_ch.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
            s1_item_reg <= in_ch.payload;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SWITCHES; i++)
            begin
                prev_level_reg[i]      <= 1'b0;
                press_start_reg[i]     <= '0;
                prev_press_time_reg[i] <= '0;
                press_tally_reg[i]     <= '0;
                single_pending_reg[i]  <= 1'b0;
                pending_since_reg[i]   <= '0;
                long_fired_reg[i]      <= 1'b0;
            end
        end
        else if (commit)
        begin
            prev_level_reg[idx]      <= lvl;
            press_start_reg[idx]     <= start_next;
            prev_press_time_reg[idx] <= ppt_next;
            press_tally_reg[idx]     <= tally_next;
            single_pending_reg[idx]  <= pend_next;
            pending_since_reg[idx]   <= since_next;
            long_fired_reg[idx]      <= lf_next;
        end
    end

    // Event register: load a new pair, or shift the second event forward
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ev_cnt_reg <= 2'd0;
        else if (advance && (new_cnt != 2'd0))
            ev_cnt_reg <= new_cnt;
        else if (out_pop)
            ev_cnt_reg <= ev_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (advance && (new_cnt != 2'd0))
        begin
            ev_sw_reg <= s1_item_reg.switch_sel;
            ev_k0_reg <= new_k0;
            ev_k1_reg <= new_k1;
        end
        else if (out_pop)
        begin
            ev_k0_reg <= ev_k1_reg;
        end
    end

    assign out_ch.valid                = (ev_cnt_reg != 2'd0);
    assign out_ch.payload.event_switch = ev_sw_reg;
    assign out_ch.payload.event_kind   = ev_k0_reg;
    assign out_ch.payload.last_event   = (ev_cnt_reg == 2'd1);

endmodule

@@ hw/rtl/fpc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpc_checker
// Port-level checks of the footswitch press classifier event channel.
// ----------------------------------------------------------------------------
`include "footswitch_press_classifier_defines.svh"

module fpc_checker
    import fpc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_switch,
    input logic [1:0] out_kind,
    input logic       out_last
);

    // A stalled beat holds
    `FPC_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_kind) && $stable(out_switch) && $stable(out_last)), "event beat changed while stalled")

    `FPC_NEVER(a_kind_legal, out_valid && (out_kind == 2'd3), "undefined event kind")

    // The only pair is normal then long
    `FPC_ASSERT(a_first_normal, (out_valid && !out_last) |-> (out_kind == KIND_NORMAL), "first of a pair is not a normal press")

    // The second event of a pair follows at once, for the same switch
    `FPC_ASSERT(a_pair_follows, (out_valid && out_ready && !out_last) |=> (out_valid && out_last && (out_kind == KIND_LONG) && $stable(out_switch)), "second event of a pair missing")

endmodule

bind footswitch_press_classifier fpc_checker u_fpc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_switch (out_ch.payload.event_switch),
    .out_kind   (out_ch.payload.event_kind),
    .out_last   (out_ch.payload.last_event)
);

@@ sim/tb_footswitch_press_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_footswitch_press_classifier
// Self-checking bench for the footswitch press classifier. A scoreboard tracks
// the per-switch press state and register settings. For every sample beat it
// predicts the normal, double and long press events, and it compares each
// event beat against the oldest prediction. Stimulus is a directed opener,
// a back-pressure burst, then random press/release sequences under a range of
// thresholds and masks. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_footswitch_press_classifier;
    import fpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_STALL     = 100;
    localparam int MAX_REPORTS    = 10;

    class press_scoreboard;
        logic        enable;
        logic [2:0]  mask;
        logic [15:0] hold_ms;
        logic [15:0] window_ms;

        logic        level_q [NUM_SWITCHES_DEF];
        logic [31:0] start_ms [NUM_SWITCHES_DEF];
        logic [31:0] last_press_ms [NUM_SWITCHES_DEF];
        logic [1:0]  tally [NUM_SWITCHES_DEF];
        logic        single_wait [NUM_SWITCHES_DEF];
        logic [31:0] single_at [NUM_SWITCHES_DEF];
        logic        long_done [NUM_SWITCHES_DEF];

        event_t      batch[$];
        event_t      expected_events[$];
        int unsigned samples;
        int unsigned events_ok;
        int unsigned mismatches;

        function new();
            enable     = ENABLE_RST;
            mask       = MASK_RST;
            hold_ms    = HOLD_RST;
            window_ms  = WINDOW_RST;
            samples    = 0;
            events_ok  = 0;
            mismatches = 0;
            for (int i = 0; i < NUM_SWITCHES_DEF; i++)
            begin
                level_q[i]       = 1'b0;
                start_ms[i]      = '0;
                last_press_ms[i] = '0;
                tally[i]         = '0;
                single_wait[i]   = 1'b0;
                single_at[i]     = '0;
                long_done[i]     = 1'b0;
            end
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] val);
            case (idx)
                CFG_ENABLE: enable    = val[0];
                CFG_MASK:   mask      = val[2:0];
                CFG_HOLD:   hold_ms   = val;
                CFG_WINDOW: window_ms = val;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_events.size();
        endfunction

        // masked events still update state; only the beat is dropped
        function void raise_event(int unsigned sw, kind_t k);
            event_t e;
            if (mask[k])
            begin
                e.event_switch = sw[0];
                e.event_kind   = k;
                e.last_event   = 1'b0;
                batch.push_back(e);
            end
        endfunction

        function void note_sample(in_item_t s);
            int unsigned sw;
            logic        lvl;
            logic [31:0] now;
            logic [31:0] gap;
            logic [31:0] held;
            event_t      e;
            samples++;
            if (!enable)
                return;
            sw  = 32'(s.switch_sel);
            lvl = s.pressed;
            now = s.now_ms;
            if (sw >= NUM_SWITCHES_DEF)
                return;

            // release a deferred single press once its window has run out
            gap = now - single_at[sw];
            if (single_wait[sw] && gap >= {16'd0, window_ms})
            begin
                raise_event(sw, KIND_NORMAL);
                single_wait[sw] = 1'b0;
                tally[sw]       = '0;
            end

            if (lvl && !level_q[sw])
            begin
                start_ms[sw] = now;
                gap = now - last_press_ms[sw];
                if (gap <= {16'd0, window_ms})
                begin
                    if (tally[sw] < TALLY_MAX)
                        tally[sw] = tally[sw] + 2'd1;
                end
                else
                    tally[sw] = 2'd1;
                last_press_ms[sw] = now;
                long_done[sw]     = 1'b0;
            end

            held = now - start_ms[sw];
            if (lvl && held >= {16'd0, hold_ms} && !long_done[sw])
            begin
                raise_event(sw, KIND_LONG);
                long_done[sw]   = 1'b1;
                tally[sw]       = '0;
                single_wait[sw] = 1'b0;
            end

            if (!lvl && level_q[sw] && !long_done[sw])
            begin
                if (tally[sw] >= TALLY_MAX)
                begin
                    raise_event(sw, KIND_DOUBLE);
                    tally[sw]       = '0;
                    single_wait[sw] = 1'b0;
                end
                else if (held < {16'd0, hold_ms})
                begin
                    single_wait[sw] = 1'b1;
                    single_at[sw]   = now;
                end
            end

            level_q[sw] = lvl;

            foreach (batch[i])
            begin
                e = batch[i];
                e.last_event = (i == batch.size() - 1);
                expected_events.push_back(e);
            end
            batch.delete();
        endfunction

        function void check_event(event_t got);
            event_t want;
            if (expected_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected event: sw=%0d kind=%0d last=%0d",
                             got.event_switch, got.event_kind, got.last_event);
                return;
            end
            want = expected_events.pop_front();
            if (got.event_switch !== want.event_switch ||
                got.event_kind !== want.event_kind ||
                got.last_event !== want.last_event)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"event mismatch: expected sw=%0d kind=%0d last=%0d,",
                              " got sw=%0d kind=%0d last=%0d"},
                             want.event_switch, want.event_kind, want.last_event,
                             got.event_switch, got.event_kind, got.last_event);
            end
            else
                events_ok++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fpc_in_if in_ch ();
    fpc_ev_if out_ch ();

    footswitch_press_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    press_scoreboard sb;

    bit          tx_steady;
    bit          rx_steady;
    bit          stall_req;
    int unsigned n_settings;
    logic [31:0] stamp;
    logic        lvl_now [NUM_SWITCHES_DEF];
    int unsigned idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random ready bursts, one long hold-off on request
    initial
    begin
        int unsigned burst_left;
        burst_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                out_ch.ready <= 1'b0;
                burst_left = LONG_STALL;
            end
            else if (burst_left > 1)
                burst_left--;
            else if (!rx_steady && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                burst_left = $urandom_range(1, 10);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                burst_left = rx_steady ? 1 : $urandom_range(1, 20);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_event(out_ch.payload);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d events outstanding",
                     idle_cycles, sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    // hold the sample until it is taken, then maybe idle a burst
    task automatic send_sample(input logic sw, input logic lvl, input logic [31:0] t);
        in_item_t s;
        s.switch_sel = sw;
        s.pressed    = lvl;
        s.now_ms     = t;
        in_ch.valid   <= 1'b1;
        in_ch.payload <= s;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_sample(s);
        if (!tx_steady && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // drain all events, then give a sample with no event time to clear
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic en, input logic [2:0] m,
                                  input logic [15:0] h, input logic [15:0] w);
        logic [15:0] vals [4];
        cfg_idx_t    idx;
        vals[0] = {15'd0, en};
        vals[1] = {13'd0, m};
        vals[2] = h;
        vals[3] = w;
        for (int i = 0; i < 4; i++)
        begin
            idx = cfg_idx_t'(i);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_reg(idx, vals[i]);
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // mostly well-formed press/release trains; some noise jumps and levels
    task automatic random_sample(input int unsigned scale);
        int unsigned pick;
        logic        sw;
        logic        lvl;
        pick = $urandom_range(0, 19);
        sw   = 1'($urandom_range(0, 1));
        if (pick == 0)
            stamp = $urandom();
        else if (pick < 3)
            stamp = stamp;
        else if (pick < 15)
            stamp = stamp + $urandom_range(0, scale);
        else
            stamp = stamp + $urandom_range(scale, 2 * scale + 2);
        if ($urandom_range(0, 9) == 0)
            lvl = 1'($urandom_range(0, 1));
        else if ($urandom_range(0, 3) != 0)
            lvl = ~lvl_now[sw];
        else
            lvl = lvl_now[sw];
        lvl_now[sw] = lvl;
        send_sample(sw, lvl, stamp);
    endtask

    initial
    begin
        logic        en;
        logic [2:0]  m;
        logic [15:0] h;
        logic [15:0] w;
        int unsigned n_items;
        int unsigned scale;

        sb = new();
        rst_n = 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_ENABLE;
        cfg_data  <= '0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        stall_req   = 1'b0;
        n_settings  = 0;
        idle_cycles = 0;
        stamp       = '0;
        lvl_now[0]  = 1'b0;
        lvl_now[1]  = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // out of reset the classifier is off: these must leave no trace
        send_sample(1'b0, 1'b1, 32'hFFFF_FFFF);
        send_sample(1'b0, 1'b0, 32'd5);

        settle();
        apply_settings(1'b1, 3'd7, HOLD_RST, WINDOW_RST);
        // short press, deferred normal released by a later sample
        send_sample(1'b0, 1'b1, 32'd100);
        send_sample(1'b0, 1'b0, 32'd150);
        send_sample(1'b0, 1'b0, 32'd500);
        // double press across the timestamp wrap
        send_sample(1'b1, 1'b1, 32'hFFFF_FF00);
        send_sample(1'b1, 1'b0, 32'hFFFF_FF10);
        send_sample(1'b1, 1'b1, 32'hFFFF_FF40);
        send_sample(1'b1, 1'b0, 32'h0000_0010);
        // held to the threshold: one long press, silent release
        send_sample(1'b0, 1'b1, 32'd1000);
        send_sample(1'b0, 1'b1, 32'd2000);
        send_sample(1'b0, 1'b0, 32'd2100);
        // released past the threshold without a held sample: nothing
        send_sample(1'b0, 1'b1, 32'd3000);
        send_sample(1'b0, 1'b0, 32'd5000);
        // leave a single press pending
        send_sample(1'b0, 1'b1, 32'd6000);
        send_sample(1'b0, 1'b0, 32'd6010);

        // zero hold: the pending normal and a long come from one sample
        settle();
        apply_settings(1'b1, 3'd7, 16'd0, WINDOW_RST);
        send_sample(1'b0, 1'b1, 32'd6400);
        send_sample(1'b0, 1'b0, 32'd6401);
        lvl_now[0] = 1'b0;
        lvl_now[1] = 1'b0;
        stamp      = 32'd7000;

        // every press fires a long event while the receiver holds off
        settle();
        apply_settings(1'b1, 3'd7, 16'd0, 16'd3);
        stall_req = 1'b1;
        tx_steady = 1'b1;
        repeat (40) random_sample(4);
        tx_steady = 1'b0;

        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            n_items = 150;
            case (ph)
                0:
                begin
                    en = 1'b1;
                    m  = 3'd7;
                    h  = 16'd50;
                    w  = 16'd20;
                end
                1:
                begin
                    en = 1'b1;
                    m  = 3'd7;
                    h  = 16'd0;
                    w  = 16'd0;
                end
                2:
                begin
                    en = 1'b1;
                    m  = 3'($urandom_range(0, 7));
                    h  = 16'hFFFF;
                    w  = 16'hFFFF;
                end
                3:
                begin
                    en      = 1'b0;
                    m       = 3'd7;
                    h       = 16'd30;
                    w       = 16'd10;
                    n_items = 30;
                end
                4:
                begin
                    en = 1'b1;
                    m  = 3'd0;
                    h  = 16'($urandom_range(0, 200));
                    w  = 16'($urandom_range(0, 200));
                end
                default:
                begin
                    en = 1'b1;
                    m  = 3'($urandom_range(1, 7));
                    h  = 16'($urandom_range(0, 200));
                    w  = 16'($urandom_range(0, 200));
                end
            endcase
            apply_settings(en, m, h, w);
            scale = ((h > w) ? h : w) + 1;
            if (ph == 7)
            begin
                tx_steady = 1'b1;
                rx_steady = 1'b1;
            end
            repeat (n_items) random_sample(scale);
        end

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d samples under %0d register settings, incl. a long receiver hold-off.",
                 sb.samples, n_settings);
        $display("%0d events matched, %0d mismatches, %0d events never seen.",
                 sb.events_ok, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
